### design/sisc_pkg.sv
package sisc_pkg;

    localparam int MemWordsDefault = 2048;
    localparam int DataW           = 32;
    localparam int LocW            = 11;
    localparam int RegIdxW         = 5;
    localparam int RegCount        = 32;
    localparam int ShW             = 13;
    localparam int ImmW            = 18;
    localparam int JtW             = 28;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_RDMEM = 2'd2,
        CMD_RDREG = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_MOVI  = 4'd3,
        OP_JEQ   = 4'd4,
        OP_AND   = 4'd5,
        OP_XORI  = 4'd6,
        OP_JMP   = 4'd7,
        OP_LSL   = 4'd8,
        OP_LSR   = 4'd9,
        OP_LOAD  = 4'd10,
        OP_STORE = 4'd11
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC1,
        S_EXEC2,
        S_RDMEM,
        S_RDREG,
        S_LDONE
    } t_state;

    typedef struct packed {
        logic [1:0]       command;
        logic [LocW-1:0]  location;
        logic [DataW-1:0] load_word;
    } t_in_word;

    typedef struct packed {
        logic [DataW-1:0]   read_data;
        logic [LocW-1:0]    next_pc;
        logic               reg_written;
        logic [RegIdxW-1:0] reg_target;
        logic [DataW-1:0]   reg_result;
        logic               store_done;
        logic [LocW-1:0]    store_address;
        logic               branch_taken;
        logic               bad_opcode;
    } t_out_word;

    typedef struct packed {
        logic               re_a;
        logic [RegIdxW-1:0] addr_a;
        logic               re_b;
        logic [RegIdxW-1:0] addr_b;
        logic               we;
        logic [RegIdxW-1:0] addr_w;
        logic [DataW-1:0]   data_w;
    } t_rf_req;

endpackage

### design/sisc_chan_if.sv
interface sisc_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/small_isa_core_step.sv
// Small 32-bit core: 32 registers and one unified word memory of MEM_WORDS words
// (a power of two). Each input word is a command: load a memory word, read a memory
// word, read a register, or fetch and execute one instruction. Memory commands and
// register reads follow one another back to back while results are taken; an instruction runs
// in steps (fetch from the single-port word memory, register reads and data access, execute
// and write back), set by the one memory port and the two-port register file. The
// result register lets a new word be accepted while the last result waits.
module small_isa_core_step #(
    parameter int MEM_WORDS = sisc_pkg::MemWordsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sisc_chan_if.sink   i_in,
    sisc_chan_if.source o_out
);
    import sisc_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    t_state           r_state;
    t_state           n_state;
    t_state           cmd_state;
    logic [AW-1:0]    r_pc;
    logic [AW-1:0]    n_pc;
    logic [DataW-1:0] r_ins;
    logic [DataW-1:0] r_a;
    logic             r_eq;
    logic [AW-1:0]    r_ea;
    t_out_word        r_out;
    logic             r_out_valid;

    logic [DataW-1:0] r_mem [MEM_WORDS];
    logic [DataW-1:0] r_mq;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_addr;
    logic [DataW-1:0] mem_wd;

    t_rf_req          rf_req;
    logic [DataW-1:0] rf_qa;
    logic [DataW-1:0] rf_qb;

    logic             can_finish;
    logic             final_state;
    logic             fin;
    logic             acc;

    logic [3:0]         op;
    logic [RegIdxW-1:0] r1;
    logic [RegIdxW-1:0] r3;
    logic [ShW-1:0]     sh;
    logic [ImmW-1:0]    imm;
    logic [JtW-1:0]     jt;

    logic [DataW-1:0] loc_wide;
    logic [DataW-1:0] ea_sum;
    logic [AW-1:0]    pc_inc;
    logic [DataW-1:0] jeq_sum;
    logic [DataW-1:0] jt_wide;
    logic [AW-1:0]    run_pc;
    logic [DataW-1:0] res;
    logic             wr;
    logic [DataW-1:0] pc_wide;
    logic [DataW-1:0] ea_wide;
    t_out_word        ow;

    sisc_rf u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rf_req),
        .o_qa    (rf_qa),
        .o_qb    (rf_qb)
    );

    // handshake
    assign can_finish  = !r_out_valid || o_out.ready;
    assign final_state = (r_state == S_EXEC2) || (r_state == S_RDMEM) ||
                         (r_state == S_RDREG) || (r_state == S_LDONE);
    assign fin         = final_state && can_finish;
    assign i_in.ready  = i_rst_n && ((r_state == S_IDLE) || fin);
    assign acc         = i_in.valid && i_in.ready;

    // decode of the latched instruction
    assign op  = r_ins[31:28];
    assign r1  = r_ins[27:23];
    assign r3  = r_ins[17:13];
    assign sh  = r_ins[ShW-1:0];
    assign imm = r_ins[ImmW-1:0];
    assign jt  = r_ins[JtW-1:0];

    assign loc_wide = 32'(i_in.data.location);
    assign ea_sum   = rf_qa + 32'(imm);
    assign pc_inc   = r_pc + AW'(1);
    assign jeq_sum  = 32'(pc_inc) + 32'(imm);
    assign jt_wide  = 32'(jt);

    always_comb begin
        case (op)
            OP_JEQ:  run_pc = r_eq ? jeq_sum[AW-1:0] : pc_inc;
            OP_JMP:  run_pc = jt_wide[AW-1:0];
            default: run_pc = pc_inc;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        if (r_state == S_EXEC2 && fin) begin
            n_pc = run_pc;
        end
    end

    always_comb begin
        case (t_cmd'(i_in.data.command))
            CMD_LOAD:  cmd_state = S_LDONE;
            CMD_RUN:   cmd_state = S_FETCH;
            CMD_RDMEM: cmd_state = S_RDMEM;
            CMD_RDREG: cmd_state = S_RDREG;
            default:   cmd_state = S_IDLE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) n_state = cmd_state;
            end
            S_FETCH: n_state = S_EXEC1;
            S_EXEC1: n_state = S_EXEC2;
            S_EXEC2, S_RDMEM, S_RDREG, S_LDONE: begin
                if (fin) n_state = acc ? cmd_state : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // execute
    always_comb begin
        wr = 1'b1;
        case (op)
            OP_ADD:  res = r_a + rf_qa;
            OP_SUB:  res = r_a - rf_qa;
            OP_MUL:  res = r_a * rf_qa;
            OP_MOVI: res = 32'(imm);
            OP_AND:  res = r_a & rf_qa;
            OP_XORI: res = r_a ^ 32'(imm);
            OP_LSL:  res = (|sh[ShW-1:5]) ? '0 : (r_a << sh[4:0]);
            OP_LSR:  res = (|sh[ShW-1:5]) ? '0 : (r_a >> sh[4:0]);
            OP_LOAD: res = r_mq;
            default: begin
                res = '0;
                wr  = 1'b0;
            end
        endcase
    end

    // memory and register file ports
    always_comb begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = n_pc;
        mem_wd   = i_in.data.load_word;
        rf_req   = '0;
        if (acc) begin
            case (t_cmd'(i_in.data.command))
                CMD_LOAD: begin
                    mem_we   = 1'b1;
                    mem_addr = loc_wide[AW-1:0];
                end
                CMD_RUN: begin
                    mem_re   = 1'b1;
                    mem_addr = n_pc;
                end
                CMD_RDMEM: begin
                    mem_re   = 1'b1;
                    mem_addr = loc_wide[AW-1:0];
                end
                CMD_RDREG: begin
                    rf_req.re_a   = 1'b1;
                    rf_req.addr_a = i_in.data.location[RegIdxW-1:0];
                end
                default: ;
            endcase
        end
        case (r_state)
            S_FETCH: begin
                rf_req.re_a   = 1'b1;
                rf_req.addr_a = r_mq[22:18];
                rf_req.re_b   = 1'b1;
                rf_req.addr_b = r_mq[27:23];
            end
            S_EXEC1: begin
                rf_req.re_a   = 1'b1;
                rf_req.addr_a = r3;
                if (op == OP_LOAD) begin
                    mem_re   = 1'b1;
                    mem_addr = ea_sum[AW-1:0];
                end else if (op == OP_STORE) begin
                    mem_we   = 1'b1;
                    mem_addr = ea_sum[AW-1:0];
                    mem_wd   = rf_qb;
                end
            end
            S_EXEC2: begin
                rf_req.we     = fin && wr;
                rf_req.addr_w = r1;
                rf_req.data_w = res;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        if (mem_re) begin
            r_mq <= r_mem[mem_addr];
        end
    end

    // result word
    assign pc_wide = 32'((r_state == S_EXEC2) ? run_pc : r_pc);
    assign ea_wide = 32'(r_ea);

    always_comb begin
        ow         = '0;
        ow.next_pc = pc_wide[LocW-1:0];
        case (r_state)
            S_EXEC2: begin
                ow.reg_written   = wr;
                ow.reg_target    = wr ? r1 : '0;
                ow.reg_result    = res;
                ow.store_done    = (op == OP_STORE);
                ow.store_address = (op == OP_STORE) ? ea_wide[LocW-1:0] : '0;
                ow.branch_taken  = ((op == OP_JEQ) && r_eq) || (op == OP_JMP);
                ow.bad_opcode    = &op[3:2];
            end
            S_RDMEM: ow.read_data = r_mq;
            S_RDREG: ow.read_data = rf_qa;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH) begin
            r_ins <= r_mq;
        end
        if (r_state == S_EXEC1) begin
            r_a  <= rf_qa;
            r_eq <= (rf_qb == rf_qa);
            r_ea <= ea_sum[AW-1:0];
        end
        if (fin) begin
            r_out <= ow;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_fetch_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |=> r_state == S_EXEC1)
        else $error("fetch not followed by execute");

    a_rf_write_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_req.we |-> (r_state == S_EXEC2) && can_finish)
        else $error("register write outside retire");

    a_mem_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !mem_re)
        else $error("memory port used twice");
`endif

endmodule

### design/sisc_rf.sv
module sisc_rf (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sisc_pkg::t_rf_req               i_req,
    output logic [sisc_pkg::DataW-1:0]      o_qa,
    output logic [sisc_pkg::DataW-1:0]      o_qb
);
    import sisc_pkg::*;

    logic [DataW-1:0]    r_mem [RegCount];
    logic [RegCount-1:0] r_valid;
    logic [DataW-1:0]    r_qa;
    logic [DataW-1:0]    r_qb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.addr_w] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr_w] <= i_req.data_w;
        end
    end

    // write-first bypass; entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (i_req.re_a) begin
            if (i_req.we && i_req.addr_w == i_req.addr_a) begin
                r_qa <= i_req.data_w;
            end else if (r_valid[i_req.addr_a]) begin
                r_qa <= r_mem[i_req.addr_a];
            end else begin
                r_qa <= '0;
            end
        end
        if (i_req.re_b) begin
            if (i_req.we && i_req.addr_w == i_req.addr_b) begin
                r_qb <= i_req.data_w;
            end else if (r_valid[i_req.addr_b]) begin
                r_qb <= r_mem[i_req.addr_b];
            end else begin
                r_qb <= '0;
            end
        end
    end

    assign o_qa = r_qa;
    assign o_qb = r_qb;

endmodule

### dv/small_isa_core_step_test.sv
module small_isa_core_step_test;
    import sisc_pkg::*;

    localparam int          MEM          = MemWordsDefault;
    localparam logic [3:0]  OP_FIRST_BAD = 4'd12;
    localparam int          N_DIRECTED   = 28;
    localparam int          N_RANDOM     = 400;
    localparam int          DRAIN_AT     = 300;
    localparam int          HOLD_AFTER   = 150;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          END_CYCLES   = 20;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          MAX_PRINTED  = 100;

    typedef struct packed {
        logic     drain_first;
        t_in_word word;
    } t_pending;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_word  in_data    = '0;
    logic      out_ready  = 1'b0;

    sisc_chan_if #(.t_payload(t_in_word))  in_ch ();
    sisc_chan_if #(.t_payload(t_out_word)) out_ch ();

    assign in_ch.valid  = in_valid;
    assign in_ch.data   = in_data;
    assign out_ch.ready = out_ready;

    small_isa_core_step #(.MEM_WORDS(MEM)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // core state, copy 0 steers stimulus, copy 1 tracks accepted words
    logic [LocW-1:0]  st_pc   [2];
    logic [DataW-1:0] st_regs [2][RegCount];
    logic [DataW-1:0] st_mem  [2][MEM];
    bit               st_ok   [2][MEM];

    t_pending  stim_q[$];
    t_out_word core_out_q[$];
    bit        drain_next = 1'b0;

    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_runs     = 0;
    int n_taken    = 0;
    int n_stores   = 0;
    int n_bad      = 0;
    int n_cycles   = 0;
    int send_wait  = 0;
    int recv_wait  = 0;
    int hold_left  = 0;
    bit hold_used  = 1'b0;

    function automatic logic [LocW-1:0] mem_index(input logic [31:0] a);
        return LocW'(a % MEM);
    endfunction

    function automatic logic [31:0] enc_r(input logic [3:0] op, input logic [4:0] rd,
                                          input logic [4:0] ra, input logic [4:0] rb,
                                          input logic [12:0] sh);
        return {op, rd, ra, rb, sh};
    endfunction

    function automatic logic [31:0] enc_i(input logic [3:0] op, input logic [4:0] rd,
                                          input logic [4:0] ra, input logic [17:0] imm);
        return {op, rd, ra, imm};
    endfunction

    function automatic t_out_word core_step(input int c, input t_in_word w);
        t_out_word        r;
        logic [31:0]      ins;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      res;
        logic [31:0]      npc;
        logic [3:0]       op;
        logic [4:0]       r1;
        logic [4:0]       r2;
        logic [4:0]       r3;
        logic [12:0]      sh;
        logic [17:0]      imm;
        logic [27:0]      jt;
        logic             wr;
        logic [LocW-1:0]  adr;
        r = '0;
        case (w.command)
            CMD_LOAD: begin
                adr = mem_index(32'(w.location));
                st_mem[c][adr] = w.load_word;
                st_ok[c][adr]  = 1'b1;
            end
            CMD_RDMEM: r.read_data = st_mem[c][mem_index(32'(w.location))];
            CMD_RDREG: r.read_data = st_regs[c][w.location[4:0]];
            CMD_RUN: begin
                ins = st_mem[c][mem_index(32'(st_pc[c]))];
                op  = ins[31:28];
                r1  = ins[27:23];
                r2  = ins[22:18];
                r3  = ins[17:13];
                sh  = ins[12:0];
                imm = ins[17:0];
                jt  = ins[27:0];
                a   = st_regs[c][r2];
                b   = st_regs[c][r3];
                npc = 32'(mem_index(32'(st_pc[c]) + 32'd1));
                wr  = 1'b1;
                res = '0;
                case (op)
                    OP_ADD:  res = a + b;
                    OP_SUB:  res = a - b;
                    OP_MUL:  res = a * b;
                    OP_MOVI: res = 32'(imm);
                    OP_AND:  res = a & b;
                    OP_XORI: res = a ^ 32'(imm);
                    OP_LSL:  res = (sh >= 13'(DataW)) ? 32'd0 : (a << sh);
                    OP_LSR:  res = (sh >= 13'(DataW)) ? 32'd0 : (a >> sh);
                    OP_LOAD: res = st_mem[c][mem_index(a + 32'(imm))];
                    default: wr = 1'b0;
                endcase
                if (op == OP_JEQ) begin
                    if (st_regs[c][r1] == st_regs[c][r2]) begin
                        npc = 32'(mem_index(npc + 32'(imm)));
                        r.branch_taken = 1'b1;
                    end
                end else if (op == OP_JMP) begin
                    npc = 32'(mem_index((npc & 32'h0F00_0000) | 32'(jt)));
                    r.branch_taken = 1'b1;
                end else if (op == OP_STORE) begin
                    adr = mem_index(a + 32'(imm));
                    st_mem[c][adr]  = st_regs[c][r1];
                    st_ok[c][adr]   = 1'b1;
                    r.store_done    = 1'b1;
                    r.store_address = adr;
                end else if (op >= OP_FIRST_BAD) begin
                    r.bad_opcode = 1'b1;
                end
                if (wr) begin
                    st_regs[c][r1] = res;
                    r.reg_written  = 1'b1;
                    r.reg_target   = r1;
                    r.reg_result   = res;
                end
                st_pc[c] = npc[LocW-1:0];
            end
            default: ;
        endcase
        r.next_pc = st_pc[c];
        return r;
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [3:0]  op;
        logic [4:0]  r1;
        logic [4:0]  r2;
        logic [4:0]  r3;
        logic [12:0] sh;
        logic [17:0] imm;
        if ($urandom_range(0, 19) == 0) begin
            op = OP_FIRST_BAD + 4'($urandom_range(0, 3));
        end else begin
            op = 4'($urandom_range(0, OP_STORE));
        end
        r1  = 5'($urandom);
        r2  = 5'($urandom);
        r3  = 5'($urandom);
        imm = 18'($urandom);
        case ($urandom_range(0, 3))
            0: sh = 13'($urandom_range(0, DataW - 1));
            1: sh = 13'(DataW);
            2: sh = 13'($urandom);
            default: sh = 13'($urandom_range(0, 3));
        endcase
        if (op == OP_JEQ && $urandom_range(0, 1) == 1) begin
            r2 = r1;
        end
        if (op == OP_JMP || op >= OP_FIRST_BAD) begin
            return {op, 28'($urandom)};
        end
        if (op == OP_MOVI || op == OP_JEQ || op == OP_XORI ||
            op == OP_LOAD || op == OP_STORE) begin
            return enc_i(op, r1, r2, imm);
        end
        return enc_r(op, r1, r2, r3, sh);
    endfunction

    task automatic push_item(input t_cmd cmd, input logic [LocW-1:0] loc,
                             input logic [31:0] data);
        t_pending p;
        p.drain_first       = drain_next;
        p.word.command      = cmd;
        p.word.location     = loc;
        p.word.load_word    = data;
        drain_next          = 1'b0;
        stim_q.push_back(p);
        void'(core_step(0, p.word));
    endtask

    // never fetch or load from a word that was not written
    task automatic plan_run();
        logic [31:0]     ins;
        logic [LocW-1:0] adr;
        if (!st_ok[0][st_pc[0]]) begin
            push_item(CMD_LOAD, st_pc[0], rand_instr());
        end
        ins = st_mem[0][st_pc[0]];
        if (ins[31:28] == OP_LOAD) begin
            adr = mem_index(st_regs[0][ins[22:18]] + 32'(ins[17:0]));
            if (!st_ok[0][adr]) begin
                push_item(CMD_LOAD, adr, $urandom);
            end
        end
        push_item(CMD_RUN, LocW'($urandom), $urandom);
    endtask

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTED) begin
            $display("ERROR cycle %0d: %s", n_cycles, msg);
        end
        n_errors++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      n_results, name, got, want));
        end
    endtask

    initial begin
        logic [31:0]     boot_prog [12];
        logic [LocW-1:0] adr;
        int              k;
        int              pick;
        int              len;
        int              n_total;
        bit              drained_once;
        drained_once = 1'b0;
        for (int c = 0; c < 2; c++) begin
            st_pc[c] = '0;
            for (k = 0; k < RegCount; k++) st_regs[c][k] = '0;
            for (k = 0; k < MEM; k++) begin
                st_mem[c][k] = '0;
                st_ok[c][k]  = 1'b0;
            end
        end

        // straight-line program touching every opcode, wrap cases, then a bad opcode at top
        boot_prog = '{
            enc_i(OP_LOAD, 5'd3, 5'd0, 18'h3FFFF),
            enc_i(OP_MOVI, 5'd1, 5'd0, 18'h3FFFF),
            enc_i(OP_XORI, 5'd2, 5'd3, 18'h3FFFF),
            enc_r(OP_ADD, 5'd4, 5'd3, 5'd3, 13'd0),
            enc_r(OP_SUB, 5'd5, 5'd0, 5'd3, 13'd0),
            enc_r(OP_MUL, 5'd6, 5'd3, 5'd3, 13'd0),
            enc_r(OP_AND, 5'd7, 5'd3, 5'd2, 13'd0),
            enc_r(OP_LSR, 5'd8, 5'd3, 5'd0, 13'd31),
            enc_r(OP_LSL, 5'd9, 5'd3, 5'd0, 13'h1FFF),
            enc_i(OP_STORE, 5'd1, 5'd3, 18'h3FFFF),
            enc_i(OP_JEQ, 5'd9, 5'd0, 18'h3F800),
            {OP_JMP, 28'hFFF_FFFF}
        };
        push_item(CMD_LOAD, 11'h7FF, 32'hFFFF_FFFF);
        for (k = 0; k < 12; k++) push_item(CMD_LOAD, LocW'(k), boot_prog[k]);
        for (k = 0; k < 13; k++) push_item(CMD_RUN, '0, '0);
        push_item(CMD_RDMEM, 11'h7FE, '0);
        push_item(CMD_RDREG, 11'h7E8, 32'hFFFF_FFFF);

        while (stim_q.size() < N_DIRECTED + N_RANDOM) begin
            if (!drained_once && stim_q.size() >= DRAIN_AT) begin
                drain_next   = 1'b1;
                drained_once = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    push_item(CMD_LOAD, mem_index(32'(st_pc[0]) + 32'(k)), rand_instr());
                end
                for (k = 0; k < len; k++) plan_run();
            end else if (pick < 80) begin
                adr = LocW'($urandom);
                while (!st_ok[0][adr]) adr++;
                push_item(CMD_RDMEM, adr, $urandom);
            end else if (pick < 88) begin
                push_item(CMD_RDREG, LocW'($urandom), $urandom);
            end else if (pick < 95) begin
                push_item(CMD_LOAD, LocW'($urandom), $urandom);
            end else begin
                plan_run();
            end
        end
        n_total = stim_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_results < n_total) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (core_out_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", core_out_q.size()));
        end
        $display("%0d command words sent, %0d results checked, %0d instructions run",
                 n_accepted, n_results, n_runs);
        $display("%0d branches taken, %0d stores, %0d bad opcodes, %0d mismatches",
                 n_taken, n_stores, n_bad, n_errors);
        if (n_errors == 0) begin
            $display("small_isa_core_step test passed");
        end else begin
            $display("small_isa_core_step test failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        logic     nxt_valid;
        t_pending nxt_item;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nxt_valid = in_valid;
            if (in_valid && in_ch.ready) begin
                core_out_q.push_back(core_step(1, in_data));
                n_accepted++;
                if (in_data.command == CMD_RUN) n_runs++;
                nxt_valid = 1'b0;
                send_wait = ((n_accepted % 80) < 20) ? 0 : $urandom_range(0, 10);
            end
            if (!nxt_valid) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (stim_q.size() != 0 &&
                             !(stim_q[0].drain_first && core_out_q.size() != 0)) begin
                    nxt_item  = stim_q.pop_front();
                    in_data   <= nxt_item.word;
                    nxt_valid = 1'b1;
                end
            end
            in_valid <= nxt_valid;
        end
    end

    always @(posedge i_clk) begin
        logic      nxt_ready;
        t_out_word got;
        t_out_word want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_ready && out_ch.valid) begin
                got = out_ch.data;
                n_results++;
                if (core_out_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no word pending", n_results));
                end else begin
                    want = core_out_q.pop_front();
                    compare_field("read_data", got.read_data, want.read_data);
                    compare_field("next_pc", 32'(got.next_pc), 32'(want.next_pc));
                    compare_field("reg_written", 32'(got.reg_written), 32'(want.reg_written));
                    compare_field("reg_target", 32'(got.reg_target), 32'(want.reg_target));
                    compare_field("reg_result", got.reg_result, want.reg_result);
                    compare_field("store_done", 32'(got.store_done), 32'(want.store_done));
                    compare_field("store_address", 32'(got.store_address),
                                  32'(want.store_address));
                    compare_field("branch_taken", 32'(got.branch_taken),
                                  32'(want.branch_taken));
                    compare_field("bad_opcode", 32'(got.bad_opcode), 32'(want.bad_opcode));
                    n_taken  += want.branch_taken;
                    n_stores += want.store_done;
                    n_bad    += want.bad_opcode;
                end
                recv_wait = ((n_results % 64) < 16) ? 0 : $urandom_range(0, 10);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = (hold_left == 0);
            end
            out_ready <= nxt_ready;
        end
    end

    // one long receiver stall so the core backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && n_results >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("small_isa_core_step test failed");
            $finish;
        end
    end

endmodule
